[src/tvg_pkg.sv]
package tvg_pkg;

    localparam int SINE_ENTRIES_DEF  = 1024;
    localparam int MAX_DIVISIONS_DEF = 1024;
    localparam int QUEUE_DEPTH       = 4;

    localparam int IDX_W      = 11;
    localparam int PHASE_W    = 17;
    localparam int STEP_W     = 16;
    localparam int RADIUS_W   = 16;
    localparam int POS_W      = 18;
    localparam int NORM_W     = 16;
    localparam int SINE_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [RADIUS_W-1:0] INNER_RADIUS_RST = 16'd256;
    localparam logic [RADIUS_W-1:0] OUTER_RADIUS_RST = 16'd512;
    localparam logic [IDX_W-1:0]    SLICE_COUNT_RST  = 11'd16;
    localparam logic [IDX_W-1:0]    STACK_COUNT_RST  = 11'd16;
    localparam logic [STEP_W-1:0]   SLICE_STEP_RST   = 16'd4096;
    localparam logic [STEP_W-1:0]   STACK_STEP_RST   = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER_RADIUS = 3'd0,
        REG_OUTER_RADIUS = 3'd1,
        REG_SLICE_COUNT  = 3'd2,
        REG_STACK_COUNT  = 3'd3,
        REG_SLICE_STEP   = 3'd4,
        REG_STACK_STEP   = 3'd5
    } cfg_idx_e;

    typedef struct packed {
        logic [RADIUS_W-1:0] inner_radius;
        logic [RADIUS_W-1:0] outer_radius;
        logic [IDX_W-1:0]    slice_count;
        logic [IDX_W-1:0]    stack_count;
        logic [STEP_W-1:0]   slice_step;
        logic [STEP_W-1:0]   stack_step;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] slice_phase;
        logic [PHASE_W-1:0] stack_phase;
        logic               last;
    } vreq_t;

    typedef struct packed {
        logic  push;
        vreq_t entry;
    } q_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [63:0]        q;
        mag = x;
        sum = $signed(x);
        for (int k = 1; k <= 8; k++)
        begin
            mag = (mag * x) >> 30;
            mag = (mag * x) >> 30;
            mag = mag / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) == 1)
            begin
                sum = sum - $signed(mag);
            end
            else
            begin
                sum = sum + $signed(mag);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        q = (64'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[SINE_W-1:0];
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned sh);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (sh - 1);
        if (v < 0)
        begin
            mag = (64'(-v) + half) >> sh;
            return -$signed(mag);
        end
        mag = (64'(v) + half) >> sh;
        return $signed(mag);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        if (v < -64'sd131072)
        begin
            return -18'sd131072;
        end
        if (v > 64'sd131071)
        begin
            return 18'sd131071;
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [63:0] v);
        if (v < -64'sd32768)
        begin
            return -16'sd32768;
        end
        if (v > 64'sd32767)
        begin
            return 16'sd32767;
        end
        return v[NORM_W-1:0];
    endfunction

endpackage

[src/tvg_if.sv]
interface tvg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface tvg_vtx_if;
    logic                                valid;
    logic                                ready;
    logic signed [tvg_pkg::POS_W-1:0]    pos_x;
    logic signed [tvg_pkg::POS_W-1:0]    pos_y;
    logic signed [tvg_pkg::POS_W-1:0]    pos_z;
    logic signed [tvg_pkg::NORM_W-1:0]   norm_x;
    logic signed [tvg_pkg::NORM_W-1:0]   norm_y;
    logic signed [tvg_pkg::NORM_W-1:0]   norm_z;
    logic        [tvg_pkg::PHASE_W-1:0]  tex_u;
    logic        [tvg_pkg::PHASE_W-1:0]  tex_v;
    logic                                last;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output norm_x, output norm_y, output norm_z,
                    output tex_u, output tex_v, output last, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input norm_x, input norm_y, input norm_z,
                  input tex_u, input tex_v, input last, output ready);
endinterface

[src/tvg_sine_rom.sv]
module tvg_sine_rom #(
    parameter int SINE_ENTRIES = tvg_pkg::SINE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [$clog2(SINE_ENTRIES+1)-1:0] addr_a,
    input  logic [$clog2(SINE_ENTRIES+1)-1:0] addr_b,
    output logic [tvg_pkg::SINE_W-1:0]        data_a,
    output logic [tvg_pkg::SINE_W-1:0]        data_b
);

    typedef logic [tvg_pkg::SINE_W-1:0] rom_t [0:SINE_ENTRIES];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i <= SINE_ENTRIES; i++)
        begin
            t[i] = tvg_pkg::sine_q15(64'(tvg_pkg::HALF_PI_Q30 * 64'(i) / SINE_ENTRIES));
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [tvg_pkg::SINE_W-1:0] data_a_reg;
    logic [tvg_pkg::SINE_W-1:0] data_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= ROM[addr_a];
            data_b_reg <= ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

[src/tvg_front.sv]
module tvg_front #(
    parameter int MAX_DIVISIONS = tvg_pkg::MAX_DIVISIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tvg_pkg::cfg_t     cfg,
    input  tvg_pkg::q_stat_t  q_stat,
    output tvg_pkg::q_wr_t    q_wr,
    tvg_req_if.sink           req
);

    localparam int CntW = ($clog2(MAX_DIVISIONS + 1) > tvg_pkg::IDX_W) ?
                          $clog2(MAX_DIVISIONS + 1) : tvg_pkg::IDX_W;

    logic [tvg_pkg::IDX_W-1:0]   slice_index_reg, slice_index_next;
    logic [tvg_pkg::IDX_W-1:0]   stack_index_reg, stack_index_next;
    logic [tvg_pkg::PHASE_W-1:0] slice_phase_reg, slice_phase_next;
    logic [tvg_pkg::PHASE_W-1:0] stack_phase_reg, stack_phase_next;

    logic [tvg_pkg::IDX_W-1:0]   cur_slice_index;
    logic [tvg_pkg::IDX_W-1:0]   cur_stack_index;
    logic [tvg_pkg::PHASE_W-1:0] cur_slice_phase;
    logic [tvg_pkg::PHASE_W-1:0] cur_stack_phase;
    logic [CntW-1:0]             slice_eff;
    logic [CntW-1:0]             stack_eff;
    logic [tvg_pkg::PHASE_W:0]   slice_sum;
    logic [tvg_pkg::PHASE_W:0]   stack_sum;
    logic [tvg_pkg::PHASE_W-1:0] slice_adv;
    logic [tvg_pkg::PHASE_W-1:0] stack_adv;
    logic                        row_end;
    logic                        grid_end;
    logic                        accept;

    assign req.ready = !q_stat.full;
    assign accept    = req.valid && req.ready;

    assign cur_slice_index = req.restart ? '0 : slice_index_reg;
    assign cur_stack_index = req.restart ? '0 : stack_index_reg;
    assign cur_slice_phase = req.restart ? '0 : slice_phase_reg;
    assign cur_stack_phase = req.restart ? '0 : stack_phase_reg;

    assign slice_eff = (CntW'(cfg.slice_count) > CntW'(MAX_DIVISIONS)) ?
                       CntW'(MAX_DIVISIONS) : CntW'(cfg.slice_count);
    assign stack_eff = (CntW'(cfg.stack_count) > CntW'(MAX_DIVISIONS)) ?
                       CntW'(MAX_DIVISIONS) : CntW'(cfg.stack_count);

    assign row_end  = CntW'(cur_slice_index) >= slice_eff;
    assign grid_end = row_end && (CntW'(cur_stack_index) >= stack_eff);

    assign slice_sum = (tvg_pkg::PHASE_W+1)'(cur_slice_phase) +
                       (tvg_pkg::PHASE_W+1)'(cfg.slice_step);
    assign stack_sum = (tvg_pkg::PHASE_W+1)'(cur_stack_phase) +
                       (tvg_pkg::PHASE_W+1)'(cfg.stack_step);
    assign slice_adv = slice_sum[tvg_pkg::PHASE_W] ? '1 : slice_sum[tvg_pkg::PHASE_W-1:0];
    assign stack_adv = stack_sum[tvg_pkg::PHASE_W] ? '1 : stack_sum[tvg_pkg::PHASE_W-1:0];

    always_comb
    begin
        slice_index_next = slice_index_reg;
        stack_index_next = stack_index_reg;
        slice_phase_next = slice_phase_reg;
        stack_phase_next = stack_phase_reg;
        if (accept)
        begin
            if (grid_end)
            begin
                slice_index_next = '0;
                stack_index_next = '0;
                slice_phase_next = '0;
                stack_phase_next = '0;
            end
            else if (row_end)
            begin
                slice_index_next = '0;
                slice_phase_next = '0;
                stack_index_next = cur_stack_index + 1'b1;
                stack_phase_next = stack_adv;
            end
            else
            begin
                slice_index_next = cur_slice_index + 1'b1;
                slice_phase_next = slice_adv;
                stack_index_next = cur_stack_index;
                stack_phase_next = cur_stack_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_index_reg <= '0;
            stack_index_reg <= '0;
            slice_phase_reg <= '0;
            stack_phase_reg <= '0;
        end
        else
        begin
            slice_index_reg <= slice_index_next;
            stack_index_reg <= stack_index_next;
            slice_phase_reg <= slice_phase_next;
            stack_phase_reg <= stack_phase_next;
        end
    end

    assign q_wr.push              = accept;
    assign q_wr.entry.slice_phase = cur_slice_phase;
    assign q_wr.entry.stack_phase = cur_stack_phase;
    assign q_wr.entry.last        = grid_end;

endmodule

[src/tvg_queue.sv]
module tvg_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tvg_pkg::q_wr_t    q_wr,
    input  logic              pop,
    output tvg_pkg::vreq_t    head,
    output tvg_pkg::q_stat_t  q_stat
);

    localparam int PtrW = $clog2(tvg_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(tvg_pkg::QUEUE_DEPTH + 1);

    tvg_pkg::vreq_t   mem_reg [tvg_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(tvg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(tvg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (q_wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !q_wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CntW'(tvg_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

[src/tvg_back.sv]
module tvg_back #(
    parameter int SINE_ENTRIES = tvg_pkg::SINE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tvg_pkg::cfg_t     cfg,
    input  tvg_pkg::vreq_t    head,
    input  tvg_pkg::q_stat_t  q_stat,
    output logic              pop,
    tvg_vtx_if.source         vtx
);

    localparam int AddrW = $clog2(SINE_ENTRIES + 1);
    localparam int MulW  = 14 + AddrW;
    localparam int SW    = tvg_pkg::SINE_W;
    localparam int PW    = tvg_pkg::PHASE_W;

    function automatic logic [AddrW-1:0] quad_index(input logic [13:0] frac);
        logic [MulW-1:0] p;
        p = MulW'(frac) * MulW'(SINE_ENTRIES);
        return p[MulW-1:14];
    endfunction

    function automatic logic signed [15:0] signed_sine(input logic [SW-1:0] raw,
                                                       input logic neg);
        logic signed [15:0] v;
        v = $signed({1'b0, raw});
        return neg ? -v : v;
    endfunction

    logic en;

    logic [AddrW-1:0] u_idx, u_mir, v_idx, v_mir;
    logic [AddrW-1:0] st_addr, ct_addr, ss_addr, cs_addr;
    logic [1:0]       u_quad, v_quad;
    logic [SW-1:0]    st_raw, ct_raw, ss_raw, cs_raw;

    logic          a_valid_reg, a_valid_next;
    logic          a_neg_st_reg, a_neg_ct_reg, a_neg_ss_reg, a_neg_cs_reg;
    logic [PW-1:0] a_tex_u_reg, a_tex_v_reg;
    logic          a_last_reg;

    logic signed [15:0] st, ct, ss, cs;
    logic signed [32:0] rct;
    logic signed [32:0] b_ring_next, b_pz_next;
    logic signed [31:0] b_nx_next, b_ny_next;

    logic               b_valid_reg, b_valid_next;
    logic signed [32:0] b_ring_reg, b_pz_reg;
    logic signed [31:0] b_nx_reg, b_ny_reg;
    logic signed [15:0] b_st_reg, b_cs_reg, b_ss_reg;
    logic [PW-1:0]      b_tex_u_reg, b_tex_v_reg;
    logic               b_last_reg;

    logic signed [48:0] c_px_next, c_py_next;
    logic               c_valid_reg, c_valid_next;
    logic signed [48:0] c_px_reg, c_py_reg;
    logic signed [32:0] c_pz_reg;
    logic signed [31:0] c_nx_reg, c_ny_reg;
    logic signed [15:0] c_st_reg;
    logic [PW-1:0]      c_tex_u_reg, c_tex_v_reg;
    logic               c_last_reg;

    logic d_valid_reg, d_valid_next;

    assign en  = !d_valid_reg || vtx.ready;
    assign pop = en && !q_stat.empty;

    assign u_quad  = head.slice_phase[15:14];
    assign v_quad  = head.stack_phase[15:14];
    assign u_idx   = quad_index(head.slice_phase[13:0]);
    assign v_idx   = quad_index(head.stack_phase[13:0]);
    assign u_mir   = AddrW'(SINE_ENTRIES) - u_idx;
    assign v_mir   = AddrW'(SINE_ENTRIES) - v_idx;
    assign st_addr = u_quad[0] ? u_mir : u_idx;
    assign ct_addr = u_quad[0] ? u_idx : u_mir;
    assign ss_addr = v_quad[0] ? v_mir : v_idx;
    assign cs_addr = v_quad[0] ? v_idx : v_mir;

    tvg_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_slice_rom (
        .clk    (clk),
        .en     (en),
        .addr_a (st_addr),
        .addr_b (ct_addr),
        .data_a (st_raw),
        .data_b (ct_raw)
    );

    tvg_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_stack_rom (
        .clk    (clk),
        .en     (en),
        .addr_a (ss_addr),
        .addr_b (cs_addr),
        .data_a (ss_raw),
        .data_b (cs_raw)
    );

    assign st = signed_sine(st_raw, a_neg_st_reg);
    assign ct = signed_sine(ct_raw, a_neg_ct_reg);
    assign ss = signed_sine(ss_raw, a_neg_ss_reg);
    assign cs = signed_sine(cs_raw, a_neg_cs_reg);

    assign rct         = 33'($signed({1'b0, cfg.inner_radius})) * 33'(ct);
    assign b_ring_next = $signed({2'b00, cfg.outer_radius, 15'd0}) + rct;
    assign b_pz_next   = 33'($signed({1'b0, cfg.inner_radius})) * 33'(st);
    assign b_nx_next   = 32'(cs) * 32'(ct);
    assign b_ny_next   = 32'(ss) * 32'(ct);

    assign c_px_next = 49'(b_ring_reg) * 49'(b_cs_reg);
    assign c_py_next = 49'(b_ring_reg) * 49'(b_ss_reg);

    assign a_valid_next = en ? pop : a_valid_reg;
    assign b_valid_next = en ? a_valid_reg : b_valid_reg;
    assign c_valid_next = en ? b_valid_reg : c_valid_reg;
    assign d_valid_next = en ? c_valid_reg : d_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_neg_st_reg <= u_quad[1];
            a_neg_ct_reg <= u_quad[1] ^ u_quad[0];
            a_neg_ss_reg <= v_quad[1];
            a_neg_cs_reg <= v_quad[1] ^ v_quad[0];
            a_tex_u_reg  <= head.slice_phase;
            a_tex_v_reg  <= head.stack_phase;
            a_last_reg   <= head.last;

            b_ring_reg  <= b_ring_next;
            b_pz_reg    <= b_pz_next;
            b_nx_reg    <= b_nx_next;
            b_ny_reg    <= b_ny_next;
            b_st_reg    <= st;
            b_cs_reg    <= cs;
            b_ss_reg    <= ss;
            b_tex_u_reg <= a_tex_u_reg;
            b_tex_v_reg <= a_tex_v_reg;
            b_last_reg  <= a_last_reg;

            c_px_reg    <= c_px_next;
            c_py_reg    <= c_py_next;
            c_pz_reg    <= b_pz_reg;
            c_nx_reg    <= b_nx_reg;
            c_ny_reg    <= b_ny_reg;
            c_st_reg    <= b_st_reg;
            c_tex_u_reg <= b_tex_u_reg;
            c_tex_v_reg <= b_tex_v_reg;
            c_last_reg  <= b_last_reg;

            vtx.pos_x  <= tvg_pkg::sat_pos(tvg_pkg::round_shift(64'(c_px_reg), 30));
            vtx.pos_y  <= tvg_pkg::sat_pos(tvg_pkg::round_shift(64'(c_py_reg), 30));
            vtx.pos_z  <= tvg_pkg::sat_pos(tvg_pkg::round_shift(64'(c_pz_reg), 15));
            vtx.norm_x <= tvg_pkg::sat_norm(tvg_pkg::round_shift(64'(c_nx_reg), 15));
            vtx.norm_y <= tvg_pkg::sat_norm(tvg_pkg::round_shift(64'(c_ny_reg), 15));
            vtx.norm_z <= c_st_reg;
            vtx.tex_u  <= c_tex_u_reg;
            vtx.tex_v  <= c_tex_v_reg;
            vtx.last   <= c_last_reg;
        end
    end

    assign vtx.valid = d_valid_reg;

endmodule

[src/torus_vertex_generator.sv]
// Torus vertex generator.
// req channel: one request per vertex; restart high returns the walk to the
//   first vertex of the grid, low advances to the next one. The walk runs
//   stacks outer, slices inner, each index inclusive from 0 to its count,
//   and wraps to the first vertex after the vertex marked last.
// vtx channel: one vertex per request, in request order: position (Q18.0),
//   normal (Q1.15), texture pair (Q1.16) and the last mark.
// cfg port: write cfg_data to register cfg_index when cfg_we is high; write
//   only while no request is in flight.
// Throughput: one vertex per cycle while vtx is ready. The front updates
//   the grid counters in the cycle of acceptance; the back runs a four-stage
//   pipeline: sine table read, ring radius and normal products, position
//   products, rounding. An accepted request is registered in the queue and
//   then passes these stages before it is valid on vtx.
// Reset: counters and phases clear, registers take their default values,
//   the queue and the pipeline empty. No clearing pass is needed.
// Stall: while vtx is not taken the pipeline holds; requests go on into the
//   four-entry queue, and req.ready drops once it is full.
module torus_vertex_generator #(
    parameter int SINE_ENTRIES  = tvg_pkg::SINE_ENTRIES_DEF,
    parameter int MAX_DIVISIONS = tvg_pkg::MAX_DIVISIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tvg_req_if.sink                          req,
    tvg_vtx_if.source                        vtx,
    input  logic                             cfg_we,
    input  logic [tvg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tvg_pkg::cfg_t    cfg_reg, cfg_next;
    tvg_pkg::q_wr_t   q_wr;
    tvg_pkg::q_stat_t q_stat;
    tvg_pkg::vreq_t   head;
    logic             pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tvg_pkg::cfg_idx_e'(cfg_index))
                tvg_pkg::REG_INNER_RADIUS: cfg_next.inner_radius = cfg_data;
                tvg_pkg::REG_OUTER_RADIUS: cfg_next.outer_radius = cfg_data;
                tvg_pkg::REG_SLICE_COUNT:
                    cfg_next.slice_count = cfg_data[tvg_pkg::IDX_W-1:0];
                tvg_pkg::REG_STACK_COUNT:
                    cfg_next.stack_count = cfg_data[tvg_pkg::IDX_W-1:0];
                tvg_pkg::REG_SLICE_STEP:   cfg_next.slice_step = cfg_data;
                tvg_pkg::REG_STACK_STEP:   cfg_next.stack_step = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inner_radius <= tvg_pkg::INNER_RADIUS_RST;
            cfg_reg.outer_radius <= tvg_pkg::OUTER_RADIUS_RST;
            cfg_reg.slice_count  <= tvg_pkg::SLICE_COUNT_RST;
            cfg_reg.stack_count  <= tvg_pkg::STACK_COUNT_RST;
            cfg_reg.slice_step   <= tvg_pkg::SLICE_STEP_RST;
            cfg_reg.stack_step   <= tvg_pkg::STACK_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tvg_front #(
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_wr   (q_wr),
        .req    (req)
    );

    tvg_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    tvg_back #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .vtx    (vtx)
    );

    a_pop_not_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty
    ) else $error("queue popped while empty");

    a_restart_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_wr.push && req.restart |->
            q_wr.entry.slice_phase == '0 && q_wr.entry.stack_phase == '0
    ) else $error("restart request does not start at the first vertex");

    a_wrap_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_wr.push && $past(q_wr.push) && $past(q_wr.entry.last) |->
            q_wr.entry.slice_phase == '0 && q_wr.entry.stack_phase == '0
    ) else $error("walk did not wrap after the last vertex");

endmodule
